@@ rtl/core/xcfp_pkg.sv @@
package xcfp_pkg;

    localparam logic [7:0] SOF_BYTE = 8'hFE;

    typedef enum logic [8:0] {
        ST_HUNT   = 9'b000000001,
        ST_CMD_HI = 9'b000000010,
        ST_CMD_LO = 9'b000000100,
        ST_LEN_HI = 9'b000001000,
        ST_LEN_LO = 9'b000010000,
        ST_DATA   = 9'b000100000,
        ST_CHECK  = 9'b001000000,
        ST_READ   = 9'b010000000,
        ST_LOAD   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic xor_sof;
        logic xor_byte;
        logic ld_cmd_hi;
        logic ld_cmd_lo;
        logic ld_len_hi;
        logic ld_len_lo;
        logic clr_count;
        logic wr_store;
        logic rd_clear;
        logic rd_next;
        logic ld_out_data;
        logic ld_out_empty;
    } cmd_t;

    typedef struct packed {
        logic is_sof;
        logic len_big;
        logic len_in_zero;
        logic len_zero;
        logic count_last;
        logic xor_match;
        logic rd_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/xcfp_ram.sv @@
module xcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/xcfp_ctrl.sv @@
module xcfp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  xcfp_pkg::sts_t sts,
    output xcfp_pkg::cmd_t cmd
);
    import xcfp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_HUNT: begin
                s_ready = 1'b1;
                if (s_valid && sts.is_sof) begin
                    cmd.xor_sof = 1'b1;
                    state_next  = ST_CMD_HI;
                end
            end
            ST_CMD_HI: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_cmd_hi = 1'b1;
                    cmd.xor_byte  = 1'b1;
                    state_next    = ST_CMD_LO;
                end
            end
            ST_CMD_LO: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_cmd_lo = 1'b1;
                    cmd.xor_byte  = 1'b1;
                    state_next    = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_len_hi = 1'b1;
                    cmd.xor_byte  = 1'b1;
                    state_next    = ST_LEN_LO;
                end
            end
            ST_LEN_LO: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_len_lo = 1'b1;
                    cmd.xor_byte  = 1'b1;
                    if (sts.len_big) begin
                        state_next = ST_HUNT;
                    end else if (sts.len_in_zero) begin
                        state_next = ST_CHECK;
                    end else begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.wr_store = 1'b1;
                    cmd.xor_byte = 1'b1;
                    if (sts.count_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    state_next = ST_HUNT;
                    if (sts.xor_match) begin
                        if (sts.len_zero) begin
                            cmd.ld_out_empty = 1'b1;
                        end else begin
                            cmd.rd_clear = 1'b1;
                            state_next   = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.ld_out_data = 1'b1;
                    if (sts.rd_last) begin
                        state_next = ST_HUNT;
                    end else begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end
endmodule

@@ rtl/core/xcfp_dp.sv @@
module xcfp_dp #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_rx_byte,
    input  xcfp_pkg::cmd_t cmd,
    output xcfp_pkg::sts_t sts,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [15:0]    m_frame_cmd,
    output logic [6:0]     m_frame_len,
    output logic [7:0]     m_payload_byte,
    output logic [5:0]     m_payload_index,
    output logic           m_payload_valid,
    output logic           m_last
);
    import xcfp_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [15:0] cmd_word_reg;
    logic [7:0]  len_hi_reg;
    logic [6:0]  len_reg;
    logic [5:0]  count_reg;
    logic [5:0]  rd_idx_reg;
    logic [7:0]  xor_reg;
    logic [7:0]  rdata;
    logic [15:0] len_in;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_cmd_reg;
    logic [6:0]  out_len_reg;
    logic [7:0]  out_byte_reg;
    logic [5:0]  out_idx_reg;
    logic        out_pv_reg;
    logic        out_last_reg;

    assign len_in = {len_hi_reg, s_rx_byte};

    always_comb begin
        sts.is_sof      = (s_rx_byte == SOF_BYTE);
        sts.len_big     = (len_in > 16'(MAX_PAYLOAD));
        sts.len_in_zero = (len_in == 16'd0);
        sts.len_zero    = (len_reg == 7'd0);
        sts.count_last  = (({1'b0, count_reg} + 7'd1) == len_reg);
        sts.xor_match   = (s_rx_byte == xor_reg);
        sts.rd_last     = (({1'b0, rd_idx_reg} + 7'd1) == len_reg);
        sts.out_free    = !out_valid_reg || m_ready;
    end

    xcfp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.wr_store),
        .waddr(count_reg[AW-1:0]),
        .wdata(s_rx_byte),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_word_reg <= '0;
            len_hi_reg   <= '0;
            len_reg      <= '0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            xor_reg      <= '0;
        end else begin
            if (cmd.xor_sof) begin
                xor_reg <= SOF_BYTE;
            end else if (cmd.xor_byte) begin
                xor_reg <= xor_reg ^ s_rx_byte;
            end
            if (cmd.ld_cmd_hi) begin
                cmd_word_reg <= {s_rx_byte, 8'd0};
            end
            if (cmd.ld_cmd_lo) begin
                cmd_word_reg <= {cmd_word_reg[15:8], s_rx_byte};
            end
            if (cmd.ld_len_hi) begin
                len_hi_reg <= s_rx_byte;
            end
            if (cmd.ld_len_lo) begin
                len_reg <= s_rx_byte[6:0];
            end
            if (cmd.clr_count) begin
                count_reg <= '0;
            end else if (cmd.wr_store) begin
                count_reg <= count_reg + 6'd1;
            end
            if (cmd.rd_clear) begin
                rd_idx_reg <= '0;
            end else if (cmd.rd_next) begin
                rd_idx_reg <= rd_idx_reg + 6'd1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out_data || cmd.ld_out_empty) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out_data) begin
            out_cmd_reg  <= cmd_word_reg;
            out_len_reg  <= len_reg;
            out_byte_reg <= rdata;
            out_idx_reg  <= rd_idx_reg;
            out_pv_reg   <= 1'b1;
            out_last_reg <= sts.rd_last;
        end else if (cmd.ld_out_empty) begin
            out_cmd_reg  <= cmd_word_reg;
            out_len_reg  <= 7'd0;
            out_byte_reg <= 8'd0;
            out_idx_reg  <= 6'd0;
            out_pv_reg   <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_cmd     = out_cmd_reg;
    assign m_frame_len     = out_len_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_payload_index = out_idx_reg;
    assign m_payload_valid = out_pv_reg;
    assign m_last          = out_last_reg;
endmodule

@@ rtl/core/xor_checked_frame_parser_top.sv @@
// Parsing: one rx beat per cycle, start byte through checksum byte, while s_valid is high;
//   the checksum beat also waits for a free output. First result beat: the cycle after the
//   checksum beat (empty frame), else after READ and LOAD. Drain: each payload beat passes READ
//   (payload RAM registered read), then LOAD (output register); input is held off meanwhile.
// Reset (aresetn, synchronous): parser returns to start-byte hunt, output empties;
//   the payload RAM is not cleared.
module xor_checked_frame_parser_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_frame_cmd,
    output logic [6:0]  m_frame_len,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_payload_index,
    output logic        m_payload_valid,
    output logic        m_last
);
    import xcfp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    xcfp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    xcfp_dp #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_rx_byte      (s_rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_cmd    (m_frame_cmd),
        .m_frame_len    (m_frame_len),
        .m_payload_byte (m_payload_byte),
        .m_payload_index(m_payload_index),
        .m_payload_valid(m_payload_valid),
        .m_last         (m_last)
    );
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import xcfp_pkg::*;

    localparam int MAX_PAYLOAD = 64;
    localparam int CYCLE_LIMIT = 150000;

    typedef enum logic [2:0] {
        P_HUNT,
        P_CMD_HI,
        P_CMD_LO,
        P_LEN_HI,
        P_LEN_LO,
        P_DATA,
        P_CHECK
    } parse_phase_t;

    typedef struct packed {
        logic [15:0] cmd;
        logic [6:0]  len;
        logic [7:0]  data;
        logic [5:0]  idx;
        logic        pvalid;
        logic        last;
    } out_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_frame_cmd;
    logic [6:0]  m_frame_len;
    logic [7:0]  m_payload_byte;
    logic [5:0]  m_payload_index;
    logic        m_payload_valid;
    logic        m_last;

    // parser copy
    parse_phase_t phase = P_HUNT;
    logic [15:0]  cmd_word = 16'h0000;
    logic [15:0]  len_word = 16'h0000;
    logic [6:0]   stored = 7'd0;
    logic [7:0]   xor_acc = 8'h00;
    logic [7:0]   payload_copy [0:63];

    out_beat_t payload_beats_due [$];
    logic [7:0] tx_payload [0:63];

    bit calm = 1'b0;
    int errors = 0;
    int cycles = 0;
    int beats_checked = 0;
    int frames_sent = 0;
    int frames_bad_sum = 0;
    int frames_oversize = 0;
    int frames_cut = 0;
    int frames_passed = 0;
    int frame_bytes_sent = 0;

    xor_checked_frame_parser_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_frame_cmd(m_frame_cmd),
        .m_frame_len(m_frame_len),
        .m_payload_byte(m_payload_byte),
        .m_payload_index(m_payload_index),
        .m_payload_valid(m_payload_valid),
        .m_last(m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("xor_checked_frame_parser_top test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 30) begin
            $display("%0t: %s got %h want %h", $time, what, got, want);
        end
    endtask

    function automatic void parse_rx_byte(input logic [7:0] c);
        out_beat_t e;
        case (phase)
            P_HUNT: begin
                if (c == SOF_BYTE) begin
                    xor_acc = SOF_BYTE;
                    phase = P_CMD_HI;
                end
            end
            P_CMD_HI: begin
                cmd_word = {c, 8'h00};
                xor_acc ^= c;
                phase = P_CMD_LO;
            end
            P_CMD_LO: begin
                cmd_word[7:0] = c;
                xor_acc ^= c;
                phase = P_LEN_HI;
            end
            P_LEN_HI: begin
                len_word = {c, 8'h00};
                xor_acc ^= c;
                phase = P_LEN_LO;
            end
            P_LEN_LO: begin
                len_word[7:0] = c;
                xor_acc ^= c;
                if (len_word > MAX_PAYLOAD) begin
                    phase = P_HUNT;
                end else if (len_word == 16'd0) begin
                    phase = P_CHECK;
                end else begin
                    stored = 7'd0;
                    phase = P_DATA;
                end
            end
            P_DATA: begin
                payload_copy[stored[5:0]] = c;
                stored = stored + 7'd1;
                xor_acc ^= c;
                if (stored >= len_word) begin
                    phase = P_CHECK;
                end
            end
            P_CHECK: begin
                if (c == xor_acc) begin
                    frames_passed++;
                    e.cmd = cmd_word;
                    e.len = len_word[6:0];
                    if (len_word == 16'd0) begin
                        e.data = 8'h00;
                        e.idx = 6'd0;
                        e.pvalid = 1'b0;
                        e.last = 1'b1;
                        payload_beats_due.push_back(e);
                    end else begin
                        for (int i = 0; i < len_word && i < 64; i++) begin
                            e.data = payload_copy[i[5:0]];
                            e.idx = i[5:0];
                            e.pvalid = 1'b1;
                            e.last = (i + 1 == len_word);
                            payload_beats_due.push_back(e);
                        end
                    end
                end
                phase = P_HUNT;
            end
            default: begin
                phase = P_HUNT;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(99) < 35) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_rx_byte(b);
    endtask

    // payload comes from tx_payload; cut limits how many bytes go out
    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                              input logic [7:0] flip, input int cut);
        logic [7:0] fb [$];
        logic [7:0] sum;
        fb.push_back(SOF_BYTE);
        fb.push_back(cmd[15:8]);
        fb.push_back(cmd[7:0]);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        if (len <= MAX_PAYLOAD) begin
            for (int n = 0; n < len; n++) fb.push_back(tx_payload[n[5:0]]);
            sum = 8'h00;
            foreach (fb[k]) sum ^= fb[k];
            fb.push_back(sum ^ flip);
        end
        frames_sent++;
        if (len > MAX_PAYLOAD) frames_oversize++;
        else if (flip != 8'h00) frames_bad_sum++;
        if (cut < fb.size()) frames_cut++;
        foreach (fb[k]) begin
            if (k < cut) begin
                send_byte(fb[k]);
                frame_bytes_sent++;
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (payload_beats_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFD);
        send_byte(8'h7F);
    endtask

    task automatic test_empty_frame();
        send_frame(16'h0000, 16'd0, 8'h00, 1000);
        send_frame(16'h8001, 16'd0, 8'h01, 1000);
    endtask

    task automatic test_oversize_length();
        tx_payload[0] = 8'h5A;
        send_frame(16'h0102, 16'h0041, 8'h00, 1000);
        send_frame(16'h0304, 16'h0100, 8'h00, 1000);
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 1000);
        send_frame(16'h4242, 16'd1, 8'h00, 1000);
    endtask

    task automatic test_start_byte_in_payload();
        tx_payload[0] = SOF_BYTE;
        tx_payload[1] = SOF_BYTE;
        tx_payload[2] = 8'h00;
        send_frame({SOF_BYTE, SOF_BYTE}, 16'd3, 8'h00, 1000);
    endtask

    task automatic test_bad_checksum();
        tx_payload[0] = 8'hC3;
        tx_payload[1] = 8'h3C;
        send_frame(16'h1234, 16'd2, 8'h80, 1000);
        send_frame(16'h1234, 16'd2, 8'h00, 1000);
    endtask

    task automatic test_cut_frame();
        tx_payload[0] = 8'h11;
        send_frame(16'hABCD, 16'd1, 8'h00, 3);
        send_frame(16'h0F0F, 16'd1, 8'h00, 1000);
        send_frame(16'hF0F0, 16'd1, 8'h00, 1000);
    endtask

    // first frame with no idling on either side; sender holds off until it drains, then a second frame with idling
    task automatic test_max_length();
        for (int i = 0; i < MAX_PAYLOAD; i++) tx_payload[i[5:0]] = i[0] ? 8'hFF : 8'h00;
        tx_payload[MAX_PAYLOAD - 1] = 8'hA5;
        calm = 1'b1;
        send_frame(16'hFFFF, 16'(MAX_PAYLOAD), 8'h00, 1000);
        wait_drained();
        calm = 1'b0;
        send_frame(16'h00FF, 16'(MAX_PAYLOAD), 8'h00, 1000);
    endtask

    task automatic test_random_traffic();
        int start;
        int sel;
        int len;
        int cut;
        logic [7:0] flip;
        start = frame_bytes_sent;
        while (frame_bytes_sent - start < 60) begin
            calm = (frame_bytes_sent - start >= 15) && (frame_bytes_sent - start < 45);
            sel = $urandom_range(99);
            if (sel < 8) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else begin
                sel = $urandom_range(99);
                if (sel < 55) len = $urandom_range(0, 8);
                else if (sel < 80) len = $urandom_range(9, MAX_PAYLOAD - 1);
                else if (sel < 88) len = MAX_PAYLOAD;
                else if (sel < 92) len = MAX_PAYLOAD + 1;
                else len = $urandom_range(MAX_PAYLOAD + 1, 65535);
                flip = ($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
                cut = ($urandom_range(99) < 5) ? $urandom_range(1, 5 + len) : 1000;
                for (int i = 0; i < MAX_PAYLOAD; i++) begin
                    tx_payload[i[5:0]] = 8'($urandom_range(255));
                end
                send_frame(16'($urandom_range(65535)), 16'(len), flip, cut);
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (payload_beats_due.size() == 0) begin
                    report_mismatch("result beat with none pending, frame_cmd",
                                    m_frame_cmd, 16'h0000);
                end else begin
                    want = payload_beats_due.pop_front();
                    beats_checked++;
                    if (m_frame_cmd !== want.cmd)
                        report_mismatch("frame_cmd", m_frame_cmd, want.cmd);
                    if (m_frame_len !== want.len)
                        report_mismatch("frame_len", 16'(m_frame_len), 16'(want.len));
                    if (m_payload_byte !== want.data)
                        report_mismatch("payload_byte", 16'(m_payload_byte),
                                        16'(want.data));
                    if (m_payload_index !== want.idx)
                        report_mismatch("payload_index", 16'(m_payload_index),
                                        16'(want.idx));
                    if (m_payload_valid !== want.pvalid)
                        report_mismatch("payload_valid", 16'(m_payload_valid),
                                        16'(want.pvalid));
                    if (m_last !== want.last)
                        report_mismatch("last", 16'(m_last), 16'(want.last));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_hunt_noise();
        test_empty_frame();
        test_oversize_length();
        test_start_byte_in_payload();
        test_bad_checksum();
        test_cut_frame();
        test_max_length();
        test_random_traffic();
        wait_drained();
        repeat (16) @(posedge aclk);
        $display("frames sent: %0d (%0d bad checksum, %0d oversize, %0d cut short), %0d passed",
                 frames_sent, frames_bad_sum, frames_oversize, frames_cut, frames_passed);
        $display("result beats checked: %0d, mismatches: %0d", beats_checked, errors);
        if (errors == 0) begin
            $display("xor_checked_frame_parser_top test passed");
        end else begin
            $display("xor_checked_frame_parser_top test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/xcfp_pkg.sv
rtl/core/xcfp_ram.sv
rtl/core/xcfp_ctrl.sv
rtl/core/xcfp_dp.sv
rtl/core/xor_checked_frame_parser_top.sv
dv/tb_top.sv
